>>> rtl/core/rfcd_pkg.sv
package rfcd_pkg;

  // Frame geometry
  localparam int unsigned FRAME_BYTES_DEF  = 380;
  localparam int unsigned COUNTER_POS      = 4;
  localparam int unsigned DATA_START       = 10;
  localparam int unsigned BLOCK_BYTES      = 92;
  localparam int unsigned BLOCKS           = 4;
  localparam int unsigned CHANNELS         = 46;
  localparam int unsigned LINE_WIDTH       = 200;

  // Frame counter windows
  localparam int unsigned FIRST_COUNTER    = 1;
  localparam int unsigned LAST_COUNTER     = 50;
  localparam int unsigned LINE_END_COUNTER = 51;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CHAN_W   = 6;
  localparam int unsigned COL_W    = 8;
  localparam int unsigned LINE_W   = 16;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned BLK_W    = $clog2(BLOCKS);
  localparam int unsigned OFS_W    = $clog2(BLOCK_BYTES);
  // full column before range check: counter bits plus block bits
  localparam int unsigned COLF_W   = BYTE_W + BLK_W;

  typedef enum logic {
    KIND_SAMPLE   = 1'b0,
    KIND_LINE_END = 1'b1
  } kind_e;

  // Where the current byte sits inside the sample area
  typedef struct packed {
    logic              in_data;
    logic              odd;
    logic [BLK_W-1:0]  blk;
    logic [CHAN_W-1:0] chan;
  } loc_t;

endpackage

>>> rtl/core/rfcd_if.sv
interface rfcd_in_if;
  import rfcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface rfcd_out_if;
  import rfcd_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [CHAN_W-1:0]   channel;
  logic [COL_W-1:0]    column;
  logic [LINE_W-1:0]   line;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output kind, output channel, output column,
                  output line, output sample, input ready);
  modport sink   (input valid, input kind, input channel, input column,
                  input line, input sample, output ready);
endinterface

>>> rtl/core/rfcd_locate.sv
module rfcd_locate #(
  parameter int unsigned PosW = 9
) (
  input  logic [PosW-1:0] pos_i,
  output rfcd_pkg::loc_t  loc_o
);
  import rfcd_pkg::*;

  logic [PosW-1:0]  rel;
  logic [PosW-1:0]  ofs_full;
  logic [BLK_W-1:0] blk;
  logic [OFS_W-1:0] ofs;

  assign rel = pos_i - PosW'(DATA_START);

  // block split by compare/subtract, no divider
  always_comb begin
    if (rel >= PosW'(3 * BLOCK_BYTES)) begin
      blk      = BLK_W'(3);
      ofs_full = rel - PosW'(3 * BLOCK_BYTES);
    end else if (rel >= PosW'(2 * BLOCK_BYTES)) begin
      blk      = BLK_W'(2);
      ofs_full = rel - PosW'(2 * BLOCK_BYTES);
    end else if (rel >= PosW'(BLOCK_BYTES)) begin
      blk      = BLK_W'(1);
      ofs_full = rel - PosW'(BLOCK_BYTES);
    end else begin
      blk      = BLK_W'(0);
      ofs_full = rel;
    end
  end

  assign ofs = ofs_full[OFS_W-1:0];

  assign loc_o.in_data = (pos_i >= PosW'(DATA_START)) &&
                         (pos_i < PosW'(DATA_START + BLOCKS * BLOCK_BYTES));
  assign loc_o.odd     = ofs[0];
  assign loc_o.blk     = blk;
  assign loc_o.chan    = ofs[OFS_W-1:1];

endmodule

>>> rtl/core/radiometer_frame_channel_demux.sv
// Radiometer frame channel demultiplexer. Takes a byte stream of fixed frames
// (FrameBytes long, 380 by default) and splits the sample area (bytes 10..377,
// four blocks of 46 big-endian 16-bit samples) into per-channel requests
// tagged with channel, column and scan line. Byte 4 of each frame is the
// frame counter: counters 1..50 emit samples at column (counter-1)*4+block,
// and counter 51 emits one line-end request at the last byte of the frame,
// after which the 16-bit line counter advances (wrapping). Frames with any
// other counter are consumed silently. Throughput is one byte per clock
// unless the input stalls: each byte is decoded in the cycle it is accepted
// and any request lands in a single output register, so the request shows
// in the cycle after its byte is accepted. The input stalls only while that
// output register is full and the sink holds off. There is no frame sync
// logic: the first byte after reset is taken as byte 0 of a frame.
module radiometer_frame_channel_demux #(
  parameter int unsigned FrameBytes = rfcd_pkg::FRAME_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rfcd_in_if.sink           in_i,
  rfcd_out_if.source        out_o
);
  import rfcd_pkg::*;

  localparam int unsigned PosW = $clog2(FrameBytes);

  // frame tracking state
  logic [PosW-1:0]   pos_q, pos_d;
  logic [BYTE_W-1:0] fc_q, fc_d;
  logic [BYTE_W-1:0] hi_q, hi_d;
  logic [LINE_W-1:0] line_q, line_d;

  // output register
  logic                out_vld_q, out_vld_d;
  kind_e               kind_q, kind_d;
  logic [CHAN_W-1:0]   chan_q, chan_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [LINE_W-1:0]   oline_q, oline_d;
  logic [SAMPLE_W-1:0] samp_q, samp_d;

  logic              accept;
  loc_t              loc;
  logic [BYTE_W-1:0] fc_eff;
  logic              fc_ok;
  logic [COLF_W-1:0] col_full;
  logic              last_byte;
  logic              samp_hit;
  logic              lend_hit;

  rfcd_locate #(
    .PosW (PosW)
  ) u_locate (
    .pos_i (pos_q),
    .loc_o (loc)
  );

  // output register frees up in the same cycle it is drained
  assign in_i.ready = !out_vld_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // the counter byte takes effect for its own byte too
  assign fc_eff = (pos_q == PosW'(COUNTER_POS)) ? in_i.data_byte : fc_q;
  assign fc_ok  = (fc_eff >= BYTE_W'(FIRST_COUNTER)) &&
                  (fc_eff <= BYTE_W'(LAST_COUNTER));

  // (counter-1)*4 + block, four blocks so a plain concat
  assign col_full  = {fc_eff - BYTE_W'(FIRST_COUNTER), loc.blk};
  assign last_byte = pos_q >= PosW'(FrameBytes - 1);

  // sample completes on the low (odd) byte
  assign samp_hit = accept && loc.in_data && loc.odd && fc_ok &&
                    (loc.chan < CHAN_W'(CHANNELS)) &&
                    (col_full < COLF_W'(LINE_WIDTH));

  assign lend_hit = accept && last_byte && !samp_hit &&
                    (fc_eff == BYTE_W'(LINE_END_COUNTER));

  always_comb begin
    pos_d  = pos_q;
    fc_d   = fc_q;
    hi_d   = hi_q;
    line_d = line_q;
    if (accept) begin
      pos_d = last_byte ? '0 : pos_q + PosW'(1);
      if (pos_q == PosW'(COUNTER_POS)) begin
        fc_d = in_i.data_byte;
      end
      if (loc.in_data && !loc.odd) begin
        hi_d = in_i.data_byte;
      end
      if (lend_hit) begin
        line_d = line_q + LINE_W'(1);
      end
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    kind_d    = kind_q;
    chan_d    = chan_q;
    col_d     = col_q;
    oline_d   = oline_q;
    samp_d    = samp_q;
    if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (samp_hit) begin
      out_vld_d = 1'b1;
      kind_d    = KIND_SAMPLE;
      chan_d    = loc.chan;
      col_d     = col_full[COL_W-1:0];
      oline_d   = line_q;
      samp_d    = {hi_q, in_i.data_byte};
    end else if (lend_hit) begin
      // line end carries the line that just finished
      out_vld_d = 1'b1;
      kind_d    = KIND_LINE_END;
      chan_d    = '0;
      col_d     = '0;
      oline_d   = line_q;
      samp_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      fc_q      <= '0;
      line_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      fc_q      <= fc_d;
      line_q    <= line_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q    <= hi_d;
    kind_q  <= kind_d;
    chan_q  <= chan_d;
    col_q   <= col_d;
    oline_q <= oline_d;
    samp_q  <= samp_d;
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.kind    = kind_q;
  assign out_o.channel = chan_q;
  assign out_o.column  = col_q;
  assign out_o.line    = oline_q;
  assign out_o.sample  = samp_q;

endmodule

>>> tb/radiometer_frame_channel_demux_tb.sv
`timescale 1ns / 1ps

module radiometer_frame_channel_demux_tb;
  import rfcd_pkg::*;

  localparam int unsigned FRAME_LEN    = FRAME_BYTES_DEF;
  localparam int unsigned ITEM_COUNT   = 1350;
  localparam int unsigned FULL_FRAMES  = 3;
  localparam int unsigned MAX_REPORTS  = 40;
  localparam int unsigned DRAIN_LIMIT  = 5000;
  localparam int unsigned TAIL_CYCLES  = 8;

  // Content styles for a generated frame
  typedef enum int {
    FILL_RANDOM,
    FILL_EXTREME
  } fill_e;

  // One expected output request
  typedef struct {
    kind_e               kind;
    logic [CHAN_W-1:0]   channel;
    logic [COL_W-1:0]    column;
    logic [LINE_W-1:0]   line;
    logic [SAMPLE_W-1:0] sample;
  } pixel_t;

  logic clk_i;
  logic rst_ni;

  rfcd_in_if  in_if ();
  rfcd_out_if out_if ();

  radiometer_frame_channel_demux dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Decoder shadow state, mirrors what the block should hold
  logic [8:0]        frame_pos = '0;
  logic [BYTE_W-1:0] frame_cnt = '0;
  logic [BYTE_W-1:0] sample_hi = '0;
  logic [LINE_W-1:0] line_cnt  = '0;

  pixel_t pending_px[$];

  int unsigned err_count  = 0;
  bit          no_idle    = 1'b0;  // both sides run flat out while set
  int unsigned hold_req   = 0;     // sink hold-off request, picked up by the sink process
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block wedges
  initial begin
    #2_000_000;
    $display("[radiometer_frame_channel_demux] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow decoder: one accepted byte in, at most one request queued.
  // Sample bytes alternate high/low; the odd byte completes the sample. The
  // line end is only raised at the last byte of a frame tagged 51, and it
  // carries the line number that is ending.
  // ---------------------------------------------------------------------------
  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    int unsigned rel;
    int unsigned blk;
    int unsigned ofs;
    int unsigned col;
    pixel_t      px;
    bit          hit;
    hit = 1'b0;
    if (frame_pos == COUNTER_POS) frame_cnt = b;
    if (frame_pos >= DATA_START && frame_pos < DATA_START + BLOCKS * BLOCK_BYTES) begin
      rel = frame_pos - DATA_START;
      blk = rel / BLOCK_BYTES;
      ofs = rel % BLOCK_BYTES;
      if (ofs % 2 == 0) begin
        sample_hi = b;
      end else if (frame_cnt >= FIRST_COUNTER && frame_cnt <= LAST_COUNTER &&
                   ofs / 2 < CHANNELS) begin
        col = (frame_cnt - 1) * BLOCKS + blk;
        if (col < LINE_WIDTH) begin
          px.kind    = KIND_SAMPLE;
          px.channel = CHAN_W'(ofs / 2);
          px.column  = COL_W'(col);
          px.line    = line_cnt;
          px.sample  = {sample_hi, b};
          pending_px.insert(pending_px.size(), px);
          hit = 1'b1;
        end
      end
    end
    if (frame_pos + 1 >= FRAME_LEN) begin
      if (frame_cnt == LINE_END_COUNTER && !hit) begin
        px.kind    = KIND_LINE_END;
        px.channel = '0;
        px.column  = '0;
        px.line    = line_cnt;
        px.sample  = '0;
        pending_px.insert(pending_px.size(), px);
        line_cnt = line_cnt + 1'b1;  // wraps at 16 bits
      end
      frame_pos = '0;
    end else begin
      frame_pos = frame_pos + 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender. valid stays high across back-to-back bytes; it only drops when a
  // gap is drawn, so it never sees two updates in the same step.
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    decode_byte(b);
  endtask

  task automatic release_input();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sender goes quiet until every queued request has come out
  task automatic wait_drain();
    release_input();
    while (pending_px.size() != 0) @(posedge clk_i);
  endtask

  // One frame, or its first nbytes bytes. Header/trailer bytes are random,
  // byte 4 is the counter. Extreme fill walks each sample through
  // 0000/00FF/FF00/FFFF by channel.
  task automatic push_frame(input logic [BYTE_W-1:0] counter, input fill_e fill,
                            input int unsigned nbytes);
    int unsigned         pos;
    int unsigned         ofs;
    logic [BYTE_W-1:0]   b;
    logic [CHAN_W-1:0]   chan;
    for (pos = 0; pos < nbytes; pos++) begin
      b = BYTE_W'($urandom_range(0, 255));
      if (pos == COUNTER_POS) begin
        b = counter;
      end else if (fill == FILL_EXTREME && pos >= DATA_START &&
                   pos < DATA_START + BLOCKS * BLOCK_BYTES) begin
        ofs  = (pos - DATA_START) % BLOCK_BYTES;
        chan = CHAN_W'(ofs / 2);
        if (ofs % 2 == 0) b = chan[1] ? 8'hFF : 8'h00;
        else              b = chan[0] ? 8'hFF : 8'h00;
      end
      push_byte(b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sink: checks every accepted request against the oldest expectation, then
  // draws its own stall. A long hold-off from a test overrides the stall.
  // ---------------------------------------------------------------------------
  task automatic report(input string what, input logic [31:0] exp_v,
                        input logic [31:0] act_v);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
  endtask

  task automatic check_request();
    pixel_t px;
    if (pending_px.size() == 0) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: unexpected request, expected none, got kind %0b ch %0d col %0d line %0d sample %0h",
                 $time, out_if.kind, out_if.channel, out_if.column, out_if.line,
                 out_if.sample);
    end else begin
      px = pending_px.pop_front();
      if (out_if.kind !== px.kind)       report("kind", px.kind, out_if.kind);
      if (out_if.channel !== px.channel) report("channel", px.channel, out_if.channel);
      if (out_if.column !== px.column)   report("column", px.column, out_if.column);
      if (out_if.line !== px.line)       report("line", px.line, out_if.line);
      if (out_if.sample !== px.sample)   report("sample", px.sample, out_if.sample);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        check_request();
        stall_left = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Counter 1: columns 0..3, every channel, sample bytes at 00 and FF
  task automatic test_first_columns();
    push_frame(8'd1, FILL_EXTREME, FRAME_LEN);
    wait_drain();
  endtask

  // Counter 51: no samples, one line end on the last byte, line advances.
  // The next frame's samples then carry the new line number.
  task automatic test_line_end();
    push_frame(8'd51, FILL_RANDOM, FRAME_LEN);
    wait_drain();
  endtask

  // Sink holds off for a long stretch while bytes keep coming at full rate,
  // so the output register fills and the input must stall. Counter 50, so
  // this also covers the last columns 196..199.
  task automatic test_backpressure();
    no_idle  = 1'b1;
    hold_req = 120;
    push_frame(8'd50, FILL_EXTREME, FRAME_LEN);
    no_idle = 1'b0;
    wait_drain();
  endtask

  // Counter 0 or above 51 must stay silent; the frame is cut short once the
  // byte count is reached
  task automatic test_silent_counters();
    logic [BYTE_W-1:0] counter;
    if ($urandom_range(0, 1) == 0) counter = 8'd0;
    else counter = BYTE_W'($urandom_range(LINE_END_COUNTER + 1, 255));
    push_frame(counter, FILL_RANDOM, ITEM_COUNT - FULL_FRAMES * FRAME_LEN);
    wait_drain();
  endtask

  initial begin
    int unsigned waited;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    out_if.ready    = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_columns();
    test_line_end();
    test_backpressure();
    test_silent_counters();

    // Let the last requests out, then keep watching for anything stray
    release_input();
    waited = 0;
    while (pending_px.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (pending_px.size() != 0) begin
      err_count++;
      $display("%0t: %0d requests never arrived, expected none left, got %0d",
               $time, pending_px.size(), pending_px.size());
    end
    if (err_count == 0) begin
      $display("[radiometer_frame_channel_demux] OK");
    end else begin
      $display("[radiometer_frame_channel_demux] ERROR");
    end
    $finish;
  end

endmodule
